### rtl/tgr_pkg.sv
// shared types and constants of the touch gesture recognizer
// configuration register map, gesture codes, poll item and settings structs
// no dependencies
`default_nettype none

package tgr_pkg;

	typedef enum logic [2:0] {
		CFG_SCREEN_LIMIT  = 3'd0,
		CFG_SWIPE_MIN     = 3'd1,
		CFG_TAP_MAX_MOVE  = 3'd2,
		CFG_TAP_MAX_MS    = 3'd3,
		CFG_LONG_PRESS_MS = 3'd4,
		CFG_COOLDOWN_MS   = 3'd5
	} cfg_idx_t;

	localparam logic [7:0] CODE_NONE  = 8'd0;
	localparam logic [7:0] CODE_UP    = 8'd1;
	localparam logic [7:0] CODE_DOWN  = 8'd2;
	localparam logic [7:0] CODE_LEFT  = 8'd3;
	localparam logic [7:0] CODE_RIGHT = 8'd4;
	localparam logic [7:0] CODE_TAP   = 8'd5;
	localparam logic [7:0] CODE_LONG  = 8'd12;

	localparam logic [12:0] RST_SCREEN_LIMIT  = 13'd240;
	localparam logic [11:0] RST_SWIPE_MIN     = 12'd30;
	localparam logic [11:0] RST_TAP_MAX_MOVE  = 12'd20;
	localparam logic [15:0] RST_TAP_MAX_MS    = 16'd500;
	localparam logic [15:0] RST_LONG_PRESS_MS = 16'd1200;
	localparam logic [15:0] RST_COOLDOWN_MS   = 16'd350;

	localparam logic [7:0] NIBBLE_MASK = 8'h0F;

	typedef struct packed {
		logic [12:0] screen_limit;
		logic [11:0] swipe_min;
		logic [11:0] tap_max_move;
		logic [15:0] tap_max_ms;
		logic [15:0] long_press_ms;
		logic [15:0] cooldown_ms;
	} cfg_t;

	typedef struct packed {
		logic        read_ok;
		logic [31:0] now_ms;
		logic [7:0]  hw_gesture;
		logic [7:0]  finger_count;
		logic [7:0]  x_high;
		logic [7:0]  x_low;
		logic [7:0]  y_high;
		logic [7:0]  y_low;
	} item_t;

endpackage

`default_nettype wire

### rtl/tgr_core.sv
// gesture state and per-poll decision logic of the touch gesture recognizer
// holds the press state, updates it on each step whose poll was read; result is combinational
// depends on tgr_pkg
`default_nettype none

module tgr_core #(
	parameter int COORD_BITS = 12
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  step,
	input  wire tgr_pkg::item_t        item,
	input  wire tgr_pkg::cfg_t         cfg,
	output logic                       res_gesture_valid,
	output logic [7:0]                 res_gesture_code,
	output logic                       res_coords_valid,
	output logic [COORD_BITS-1:0]      res_pos_x,
	output logic [COORD_BITS-1:0]      res_pos_y
);

	localparam int CW = COORD_BITS + 1;
	localparam int EW = 17;

	logic                  was_touched_q;
	logic [31:0]           start_time_q;
	logic [COORD_BITS-1:0] start_x_q;
	logic [COORD_BITS-1:0] start_y_q;
	logic [COORD_BITS-1:0] last_x_q;
	logic [COORD_BITS-1:0] last_y_q;
	logic [31:0]           last_emit_q;
	logic [7:0]            latched_q;

	logic                  was_touched_d;
	logic [31:0]           start_time_d;
	logic [COORD_BITS-1:0] start_x_d;
	logic [COORD_BITS-1:0] start_y_d;
	logic [COORD_BITS-1:0] last_x_d;
	logic [COORD_BITS-1:0] last_y_d;
	logic [31:0]           last_emit_d;
	logic [7:0]            latched_d;

	logic [15:0]           raw_x;
	logic [15:0]           raw_y;
	logic [COORD_BITS-1:0] x;
	logic [COORD_BITS-1:0] y;
	logic                  touched;
	logic [31:0]           since_emit;
	logic [31:0]           duration;
	logic                  cool_ok;
	logic signed [CW-1:0]  dx;
	logic signed [CW-1:0]  dy;
	logic [CW-1:0]         ax;
	logic [CW-1:0]         ay;
	logic [EW-1:0]         ax_e;
	logic [EW-1:0]         ay_e;
	logic [EW-1:0]         swipe_e;
	logic [EW-1:0]         tap_move_e;
	logic                  emit;
	logic [7:0]            code;

	assign raw_x = {item.x_high & tgr_pkg::NIBBLE_MASK, item.x_low} & 16'h0FFF;
	assign raw_y = {item.y_high & tgr_pkg::NIBBLE_MASK, item.y_low} & 16'h0FFF;
	assign x = raw_x[COORD_BITS-1:0];
	assign y = raw_y[COORD_BITS-1:0];

	assign touched = (item.finger_count == 8'd1)
		&& (EW'(x) < EW'(cfg.screen_limit))
		&& (EW'(y) < EW'(cfg.screen_limit));

	assign since_emit = item.now_ms - last_emit_q;
	assign duration   = item.now_ms - start_time_q;
	assign cool_ok    = since_emit >= {16'd0, cfg.cooldown_ms};

	assign dx = $signed({1'b0, last_x_q}) - $signed({1'b0, start_x_q});
	assign dy = $signed({1'b0, last_y_q}) - $signed({1'b0, start_y_q});
	assign ax = dx[CW-1] ? CW'(-dx) : CW'(dx);
	assign ay = dy[CW-1] ? CW'(-dy) : CW'(dy);
	assign ax_e       = EW'(ax);
	assign ay_e       = EW'(ay);
	assign swipe_e    = EW'(cfg.swipe_min);
	assign tap_move_e = EW'(cfg.tap_max_move);

	always_comb begin
		was_touched_d = was_touched_q;
		start_time_d  = start_time_q;
		start_x_d     = start_x_q;
		start_y_d     = start_y_q;
		last_x_d      = last_x_q;
		last_y_d      = last_y_q;
		last_emit_d   = last_emit_q;
		latched_d     = latched_q;
		emit          = 1'b0;
		code          = tgr_pkg::CODE_NONE;
		if (!touched) begin
			if (was_touched_q && cool_ok) begin
				if (ax_e > swipe_e && ax_e > ay_e) begin
					emit = 1'b1;
					code = (dx > 0) ? tgr_pkg::CODE_RIGHT : tgr_pkg::CODE_LEFT;
				end else if (ay_e > swipe_e && ay_e > ax_e) begin
					emit = 1'b1;
					code = (dy > 0) ? tgr_pkg::CODE_DOWN : tgr_pkg::CODE_UP;
				end else if (duration < {16'd0, cfg.tap_max_ms} && ax_e < tap_move_e
					&& ay_e < tap_move_e) begin
					emit = 1'b1;
					code = tgr_pkg::CODE_TAP;
				end
				if (emit) begin
					last_emit_d = item.now_ms;
				end
			end
			was_touched_d = 1'b0;
			latched_d     = tgr_pkg::CODE_NONE;
		end else if (!cool_ok) begin
			was_touched_d = 1'b1;
		end else if (item.hw_gesture != tgr_pkg::CODE_NONE) begin
			if (latched_q == tgr_pkg::CODE_NONE) begin
				latched_d     = item.hw_gesture;
				last_emit_d   = item.now_ms;
				was_touched_d = 1'b1;
				emit          = 1'b1;
				code          = item.hw_gesture;
			end
		end else if (!was_touched_q) begin
			was_touched_d = 1'b1;
			start_time_d  = item.now_ms;
			start_x_d     = x;
			start_y_d     = y;
			last_x_d      = x;
			last_y_d      = y;
		end else begin
			last_x_d = x;
			last_y_d = y;
			if (start_time_q != 32'd0 && duration > {16'd0, cfg.long_press_ms}) begin
				start_time_d = 32'd0;
				last_emit_d  = item.now_ms;
				latched_d    = tgr_pkg::CODE_LONG;
				emit         = 1'b1;
				code         = tgr_pkg::CODE_LONG;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			was_touched_q <= 1'b0;
			start_time_q  <= '0;
			start_x_q     <= '0;
			start_y_q     <= '0;
			last_x_q      <= '0;
			last_y_q      <= '0;
			last_emit_q   <= '0;
			latched_q     <= tgr_pkg::CODE_NONE;
		end else if (step && item.read_ok) begin
			was_touched_q <= was_touched_d;
			start_time_q  <= start_time_d;
			start_x_q     <= start_x_d;
			start_y_q     <= start_y_d;
			last_x_q      <= last_x_d;
			last_y_q      <= last_y_d;
			last_emit_q   <= last_emit_d;
			latched_q     <= latched_d;
		end
	end

	assign res_gesture_valid = item.read_ok & emit;
	assign res_gesture_code  = item.read_ok ? code : tgr_pkg::CODE_NONE;
	assign res_coords_valid  = item.read_ok;
	assign res_pos_x         = item.read_ok ? x : '0;
	assign res_pos_y         = item.read_ok ? y : '0;

endmodule

`default_nettype wire

### rtl/touch_gesture_recognizer_unit.sv
// Touch gesture recognizer. Each input transfer is one poll of a touch controller and yields
// exactly one result transfer: the decoded position and, when one fires, a gesture code (swipe,
// tap, long press or the controller's own code). A poll is taken into an input register and its
// result is loaded into an output register when it is empty or its result is taken; one poll
// per clock cycle is sustained while the output is not stalled, the press state being updated
// in the same cycle in which a poll moves from the input register to the output register. A
// result waiting on a stalled output does not block the next poll from entering a free input
// register. The six settings are written through the always-ready configuration channel; the
// user must do so only while no poll is in flight, which the block does not enforce.
// depends on tgr_pkg and tgr_core
`default_nettype none

module touch_gesture_recognizer_unit #(
	parameter int COORD_BITS = 12
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic                  read_ok,
	input  wire logic [31:0]           now_ms,
	input  wire logic [7:0]            hw_gesture,
	input  wire logic [7:0]            finger_count,
	input  wire logic [7:0]            x_high,
	input  wire logic [7:0]            x_low,
	input  wire logic [7:0]            y_high,
	input  wire logic [7:0]            y_low,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic                       gesture_valid,
	output logic [7:0]                 gesture_code,
	output logic                       coords_valid,
	output logic [COORD_BITS-1:0]      pos_x,
	output logic [COORD_BITS-1:0]      pos_y,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [2:0]            cfg_index,
	input  wire logic [15:0]           cfg_data
);

	tgr_pkg::cfg_t         cfg_q;
	tgr_pkg::item_t        item_s1;
	logic                  valid_s1;
	logic                  adv_s1;
	logic                  out_valid_q;
	logic                  gesture_valid_q;
	logic [7:0]            gesture_code_q;
	logic                  coords_valid_q;
	logic [COORD_BITS-1:0] pos_x_q;
	logic [COORD_BITS-1:0] pos_y_q;
	logic                  res_gesture_valid;
	logic [7:0]            res_gesture_code;
	logic                  res_coords_valid;
	logic [COORD_BITS-1:0] res_pos_x;
	logic [COORD_BITS-1:0] res_pos_y;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.screen_limit  <= tgr_pkg::RST_SCREEN_LIMIT;
			cfg_q.swipe_min     <= tgr_pkg::RST_SWIPE_MIN;
			cfg_q.tap_max_move  <= tgr_pkg::RST_TAP_MAX_MOVE;
			cfg_q.tap_max_ms    <= tgr_pkg::RST_TAP_MAX_MS;
			cfg_q.long_press_ms <= tgr_pkg::RST_LONG_PRESS_MS;
			cfg_q.cooldown_ms   <= tgr_pkg::RST_COOLDOWN_MS;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				tgr_pkg::CFG_SCREEN_LIMIT:  cfg_q.screen_limit  <= cfg_data[12:0];
				tgr_pkg::CFG_SWIPE_MIN:     cfg_q.swipe_min     <= cfg_data[11:0];
				tgr_pkg::CFG_TAP_MAX_MOVE:  cfg_q.tap_max_move  <= cfg_data[11:0];
				tgr_pkg::CFG_TAP_MAX_MS:    cfg_q.tap_max_ms    <= cfg_data;
				tgr_pkg::CFG_LONG_PRESS_MS: cfg_q.long_press_ms <= cfg_data;
				tgr_pkg::CFG_COOLDOWN_MS:   cfg_q.cooldown_ms   <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	assign adv_s1   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1.read_ok      <= read_ok;
			item_s1.now_ms       <= now_ms;
			item_s1.hw_gesture   <= hw_gesture;
			item_s1.finger_count <= finger_count;
			item_s1.x_high       <= x_high;
			item_s1.x_low        <= x_low;
			item_s1.y_high       <= y_high;
			item_s1.y_low        <= y_low;
		end
	end

	tgr_core #(
		.COORD_BITS(COORD_BITS)
	) u_core (
		.clk               (clk),
		.arst_n            (arst_n),
		.step              (adv_s1),
		.item              (item_s1),
		.cfg               (cfg_q),
		.res_gesture_valid (res_gesture_valid),
		.res_gesture_code  (res_gesture_code),
		.res_coords_valid  (res_coords_valid),
		.res_pos_x         (res_pos_x),
		.res_pos_y         (res_pos_y)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			gesture_valid_q <= res_gesture_valid;
			gesture_code_q  <= res_gesture_code;
			coords_valid_q  <= res_coords_valid;
			pos_x_q         <= res_pos_x;
			pos_y_q         <= res_pos_y;
		end
	end

	assign out_valid     = out_valid_q;
	assign gesture_valid = gesture_valid_q;
	assign gesture_code  = gesture_code_q;
	assign coords_valid  = coords_valid_q;
	assign pos_x         = pos_x_q;
	assign pos_y         = pos_y_q;

endmodule

`default_nettype wire

### dv/tgr_poll_checker.sv
// result checker for the touch gesture recognizer: tracks presses and settings on its own
// and compares every result transfer with the oldest predicted one
// depends on tgr_pkg
`default_nettype none

module tgr_poll_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_stall,
	input  wire logic        read_ok,
	input  wire logic [31:0] now_ms,
	input  wire logic [7:0]  hw_gesture,
	input  wire logic [7:0]  finger_count,
	input  wire logic [7:0]  x_high,
	input  wire logic [7:0]  x_low,
	input  wire logic [7:0]  y_high,
	input  wire logic [7:0]  y_low,
	input  wire logic        out_valid,
	input  wire logic        out_stall,
	input  wire logic        gesture_valid,
	input  wire logic [7:0]  gesture_code,
	input  wire logic        coords_valid,
	input  wire logic [11:0] pos_x,
	input  wire logic [11:0] pos_y,
	input  wire logic        cfg_valid,
	input  wire logic        cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	output int               mismatches,
	output int               pending,
	output int               results_checked,
	output int               gestures_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic        gesture_valid;
		logic [7:0]  gesture_code;
		logic        coords_valid;
		logic [11:0] pos_x;
		logic [11:0] pos_y;
	} poll_result_t;

	tgr_pkg::cfg_t settings;
	logic          pressed;
	logic [31:0]   press_ms;
	logic [11:0]   org_x, org_y, cur_x, cur_y;
	logic [31:0]   emit_ms;
	logic [7:0]    held_code;
	poll_result_t  due_results[$];
	poll_result_t  want;

	function automatic poll_result_t track_press(tgr_pkg::item_t p);
		poll_result_t r;
		logic [11:0]  x, y;
		logic         touched, fire;
		logic [7:0]   code;
		logic [31:0]  since_emit, held;
		int           dx, dy, ax, ay;
		r = '0;
		fire = 1'b0;
		code = tgr_pkg::CODE_NONE;
		if (!p.read_ok)
			return r;
		x = {p.x_high[3:0], p.x_low};
		y = {p.y_high[3:0], p.y_low};
		touched = (p.finger_count == 8'd1) && ({1'b0, x} < settings.screen_limit) &&
			({1'b0, y} < settings.screen_limit);
		since_emit = p.now_ms - emit_ms;
		if (!touched) begin
			if (pressed) begin
				held = p.now_ms - press_ms;
				dx = int'(cur_x) - int'(org_x);
				dy = int'(cur_y) - int'(org_y);
				ax = dx < 0 ? -dx : dx;
				ay = dy < 0 ? -dy : dy;
				if (since_emit >= {16'd0, settings.cooldown_ms}) begin
					if (ax > int'(settings.swipe_min) && ax > ay) begin
						fire = 1'b1;
						code = dx > 0 ? tgr_pkg::CODE_RIGHT : tgr_pkg::CODE_LEFT;
					end else if (ay > int'(settings.swipe_min) && ay > ax) begin
						fire = 1'b1;
						code = dy > 0 ? tgr_pkg::CODE_DOWN : tgr_pkg::CODE_UP;
					end else if (held < {16'd0, settings.tap_max_ms} &&
						ax < int'(settings.tap_max_move) && ay < int'(settings.tap_max_move)) begin
						fire = 1'b1;
						code = tgr_pkg::CODE_TAP;
					end
					if (fire)
						emit_ms = p.now_ms;
				end
			end
			pressed = 1'b0;
			held_code = tgr_pkg::CODE_NONE;
		end else if (since_emit < {16'd0, settings.cooldown_ms}) begin
			// start point is not captured here
			pressed = 1'b1;
		end else if (p.hw_gesture != tgr_pkg::CODE_NONE) begin
			if (held_code == tgr_pkg::CODE_NONE) begin
				held_code = p.hw_gesture;
				emit_ms = p.now_ms;
				pressed = 1'b1;
				fire = 1'b1;
				code = p.hw_gesture;
			end
		end else if (!pressed) begin
			pressed = 1'b1;
			press_ms = p.now_ms;
			org_x = x;
			org_y = y;
			cur_x = x;
			cur_y = y;
		end else begin
			cur_x = x;
			cur_y = y;
			held = p.now_ms - press_ms;
			if (press_ms != 32'd0 && held > {16'd0, settings.long_press_ms}) begin
				press_ms = 32'd0;
				emit_ms = p.now_ms;
				held_code = tgr_pkg::CODE_LONG;
				fire = 1'b1;
				code = tgr_pkg::CODE_LONG;
			end
		end
		r.gesture_valid = fire;
		r.gesture_code = fire ? code : tgr_pkg::CODE_NONE;
		r.coords_valid = 1'b1;
		r.pos_x = x;
		r.pos_y = y;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settings = '{tgr_pkg::RST_SCREEN_LIMIT, tgr_pkg::RST_SWIPE_MIN,
				tgr_pkg::RST_TAP_MAX_MOVE, tgr_pkg::RST_TAP_MAX_MS,
				tgr_pkg::RST_LONG_PRESS_MS, tgr_pkg::RST_COOLDOWN_MS};
			pressed = 1'b0;
			press_ms = '0;
			org_x = '0;
			org_y = '0;
			cur_x = '0;
			cur_y = '0;
			emit_ms = '0;
			held_code = tgr_pkg::CODE_NONE;
			due_results.delete();
			mismatches = 0;
			pending = 0;
			results_checked = 0;
			gestures_seen = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					tgr_pkg::CFG_SCREEN_LIMIT:  settings.screen_limit = cfg_data[12:0];
					tgr_pkg::CFG_SWIPE_MIN:     settings.swipe_min = cfg_data[11:0];
					tgr_pkg::CFG_TAP_MAX_MOVE:  settings.tap_max_move = cfg_data[11:0];
					tgr_pkg::CFG_TAP_MAX_MS:    settings.tap_max_ms = cfg_data;
					tgr_pkg::CFG_LONG_PRESS_MS: settings.long_press_ms = cfg_data;
					tgr_pkg::CFG_COOLDOWN_MS:   settings.cooldown_ms = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				due_results.push_back(track_press({read_ok, now_ms, hw_gesture, finger_count,
					x_high, x_low, y_high, y_low}));
			if (out_valid && !out_stall) begin
				if (due_results.size() == 0) begin
					mismatches++;
					$error("result transfer with no poll outstanding");
				end else begin
					want = due_results.pop_front();
					results_checked++;
					if (gesture_valid)
						gestures_seen++;
					if (gesture_valid !== want.gesture_valid) begin
						mismatches++;
						$error("gesture_valid: expected %0d, got %0d", want.gesture_valid,
							gesture_valid);
					end
					if (gesture_code !== want.gesture_code) begin
						mismatches++;
						$error("gesture_code: expected %0d, got %0d", want.gesture_code,
							gesture_code);
					end
					if (coords_valid !== want.coords_valid) begin
						mismatches++;
						$error("coords_valid: expected %0d, got %0d", want.coords_valid,
							coords_valid);
					end
					if (pos_x !== want.pos_x) begin
						mismatches++;
						$error("pos_x: expected %0d, got %0d", want.pos_x, pos_x);
					end
					if (pos_y !== want.pos_y) begin
						mismatches++;
						$error("pos_y: expected %0d, got %0d", want.pos_y, pos_y);
					end
				end
			end
			pending = due_results.size();
		end
	end

endmodule

`default_nettype wire

### dv/tb_touch_gesture_recognizer_unit.sv
// top of the touch gesture recognizer testbench: clock, reset, poll and settings stimulus
// with random idling and stalls, and the final verdict
// depends on tgr_pkg, touch_gesture_recognizer_unit and tgr_poll_checker
`default_nettype none

module tb_touch_gesture_recognizer_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASES = 8;
	localparam int PHASE_POLLS = 150;

	logic          clk, arst_n;
	logic          in_valid, in_stall;
	logic          read_ok;
	logic [31:0]   now_ms;
	logic [7:0]    hw_gesture, finger_count, x_high, x_low, y_high, y_low;
	logic          out_valid, out_stall;
	logic          gesture_valid, coords_valid;
	logic [7:0]    gesture_code;
	logic [11:0]   pos_x, pos_y;
	logic          cfg_valid, cfg_ready;
	logic [2:0]    cfg_index;
	logic [15:0]   cfg_data;

	int            mismatches, pending, results_checked, gestures_seen;
	int            polls_sent = 0;
	int            cycles = 0;
	int            lim;
	bit            quiet = 1'b0;
	bit            hold_rx = 1'b0;
	logic [31:0]   clock_ms;
	tgr_pkg::cfg_t cur;

	touch_gesture_recognizer_unit dut (.*);

	tgr_poll_checker poll_check (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			out_stall <= hold_rx || (!quiet && $urandom_range(99) < 14);
		end
	end

	// long receiver hold while polls keep coming
	initial begin
		wait (polls_sent >= 650);
		@(posedge clk);
		hold_rx = 1'b1;
		repeat (80) @(posedge clk);
		hold_rx = 1'b0;
	end

	function automatic logic [31:0] pick_gap();
		int roll;
		roll = $urandom_range(19);
		if (roll < 12)
			return $urandom_range(60, 1);
		if (roll < 16)
			return $urandom_range(int'(cur.tap_max_ms) + 50, 0);
		if (roll < 19)
			return $urandom_range(int'(cur.long_press_ms) + 400, 0);
		return $urandom_range(100000, 0);
	endfunction

	function automatic int clamp_coord(int v);
		return v < 0 ? 0 : (v >= lim ? lim - 1 : v);
	endfunction

	task automatic send_poll(bit ok, logic [31:0] t, logic [7:0] hw, logic [7:0] fingers,
		logic [11:0] x, logic [11:0] y);
		while (!quiet && $urandom_range(99) < 14) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		read_ok <= ok;
		now_ms <= t;
		hw_gesture <= hw;
		finger_count <= fingers;
		x_high <= {4'($urandom), x[11:8]};
		x_low <= x[7:0];
		y_high <= {4'($urandom), y[11:8]};
		y_low <= y[7:0];
		do @(posedge clk); while (in_stall);
		polls_sent++;
		@(negedge clk);
	endtask

	task automatic write_reg(tgr_pkg::cfg_idx_t idx, logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	initial begin
		int target;
		in_valid = 1'b0;
		read_ok = 1'b0;
		now_ms = '0;
		hw_gesture = '0;
		finger_count = '0;
		x_high = '0;
		x_low = '0;
		y_high = '0;
		y_low = '0;
		cfg_valid = 1'b0;
		cfg_index = tgr_pkg::CFG_SCREEN_LIMIT;
		cfg_data = '0;
		arst_n = 1'b0;
		cur = '{tgr_pkg::RST_SCREEN_LIMIT, tgr_pkg::RST_SWIPE_MIN, tgr_pkg::RST_TAP_MAX_MOVE,
			tgr_pkg::RST_TAP_MAX_MS, tgr_pkg::RST_LONG_PRESS_MS, tgr_pkg::RST_COOLDOWN_MS};
		lim = int'(cur.screen_limit);
		clock_ms = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed polls under the reset settings
		send_poll(1'b0, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 12'hFFF, 12'hFFF);
		send_poll(1'b1, 32'd100, tgr_pkg::CODE_NONE, 8'd1, 12'd5, 12'd5);
		send_poll(1'b1, 32'd110, tgr_pkg::CODE_NONE, 8'd0, 12'd0, 12'd0);
		send_poll(1'b1, 32'd1000, tgr_pkg::CODE_NONE, 8'd1, 12'd100, 12'd100);
		send_poll(1'b1, 32'd1050, tgr_pkg::CODE_NONE, 8'd1, 12'd100, 12'd160);
		send_poll(1'b1, 32'd1100, tgr_pkg::CODE_NONE, 8'd0, 12'd0, 12'd0);
		send_poll(1'b1, 32'd2000, tgr_pkg::CODE_NONE, 8'd1, 12'd100, 12'd160);
		send_poll(1'b1, 32'd2050, tgr_pkg::CODE_NONE, 8'd1, 12'd100, 12'd100);
		send_poll(1'b1, 32'd2100, tgr_pkg::CODE_NONE, 8'd0, 12'd0, 12'd0);
		send_poll(1'b1, 32'd3000, tgr_pkg::CODE_NONE, 8'd1, 12'd200, 12'd50);
		send_poll(1'b1, 32'd3050, tgr_pkg::CODE_NONE, 8'd1, 12'd120, 12'd50);
		send_poll(1'b1, 32'd3100, tgr_pkg::CODE_NONE, 8'd0, 12'd0, 12'd0);
		send_poll(1'b1, 32'd4000, tgr_pkg::CODE_NONE, 8'd1, 12'd120, 12'd50);
		send_poll(1'b1, 32'd4050, tgr_pkg::CODE_NONE, 8'd1, 12'd200, 12'd50);
		send_poll(1'b1, 32'd4100, tgr_pkg::CODE_NONE, 8'd0, 12'd0, 12'd0);
		send_poll(1'b1, 32'd5000, tgr_pkg::CODE_NONE, 8'd1, 12'd10, 12'd10);
		send_poll(1'b1, 32'd5100, tgr_pkg::CODE_NONE, 8'd1, 12'd12, 12'd12);
		send_poll(1'b1, 32'd5200, tgr_pkg::CODE_NONE, 8'd0, 12'd0, 12'd0);
		send_poll(1'b1, 32'd6000, tgr_pkg::CODE_NONE, 8'd1, 12'd50, 12'd50);
		send_poll(1'b1, 32'd7300, tgr_pkg::CODE_NONE, 8'd1, 12'd50, 12'd50);
		send_poll(1'b1, 32'd7800, tgr_pkg::CODE_NONE, 8'd1, 12'd50, 12'd240);
		send_poll(1'b1, 32'd9000, 8'h0B, 8'd1, 12'd30, 12'd30);
		send_poll(1'b1, 32'd9500, 8'hFF, 8'd1, 12'd30, 12'd30);
		send_poll(1'b1, 32'd9600, tgr_pkg::CODE_NONE, 8'd2, 12'd30, 12'd30);
		// press that starts at time zero never turns into a long press
		send_poll(1'b1, 32'd0, tgr_pkg::CODE_NONE, 8'd1, 12'd239, 12'd239);
		send_poll(1'b1, 32'd2000, tgr_pkg::CODE_NONE, 8'd1, 12'd239, 12'd239);
		send_poll(1'b1, 32'd2100, tgr_pkg::CODE_NONE, 8'd0, 12'd0, 12'd0);
		clock_ms = 32'd20000;

		for (int ph = 0; ph < PHASES; ph++) begin
			in_valid <= 1'b0;
			wait (pending == 0);
			repeat (4) @(negedge clk);
			case (ph)
				1: cur = '{13'h1000, 12'd0, 12'hFFF, 16'hFFFF, 16'd0, 16'd0};
				2: cur = '{13'd1, 12'hFFF, 12'd0, 16'd0, 16'hFFFF, 16'hFFFF};
				3: cur = '{13'd0, 12'd30, 12'd20, 16'd500, 16'd1200, 16'd350};
				default: begin
					cur.screen_limit = $urandom_range(1) ? 13'($urandom_range(400, 1)) :
						13'($urandom_range(4096, 1));
					cur.swipe_min = 12'($urandom_range(200, 0));
					cur.tap_max_move = 12'($urandom_range(200, 0));
					cur.tap_max_ms = 16'($urandom_range(1500, 0));
					cur.long_press_ms = 16'($urandom_range(3000, 0));
					cur.cooldown_ms = 16'($urandom_range(800, 0));
				end
			endcase
			lim = int'(cur.screen_limit);
			quiet = (ph == 4);
			if (ph == 5)
				clock_ms = 32'hFFFF_C000;
			write_reg(tgr_pkg::CFG_SCREEN_LIMIT, {3'd0, cur.screen_limit});
			write_reg(tgr_pkg::CFG_SWIPE_MIN, {4'd0, cur.swipe_min});
			write_reg(tgr_pkg::CFG_TAP_MAX_MOVE, {4'd0, cur.tap_max_move});
			write_reg(tgr_pkg::CFG_TAP_MAX_MS, cur.tap_max_ms);
			write_reg(tgr_pkg::CFG_LONG_PRESS_MS, cur.long_press_ms);
			write_reg(tgr_pkg::CFG_COOLDOWN_MS, cur.cooldown_ms);
			cfg_valid <= 1'b0;
			@(negedge clk);

			target = polls_sent + PHASE_POLLS;
			while (polls_sent < target) begin : one_gesture
				int roll, x, y, v, vx, vy, rx;
				logic [7:0] fingers;
				roll = $urandom_range(99);
				if (roll < 8) begin
					send_poll(1'b0, $urandom, 8'($urandom), 8'($urandom), 12'($urandom),
						12'($urandom));
				end else if (roll < 20 || lim == 0) begin
					case ($urandom_range(3))
						0: fingers = 8'd0;
						1: fingers = 8'd1;
						2: fingers = 8'd2;
						default: fingers = 8'($urandom);
					endcase
					clock_ms += pick_gap();
					send_poll(1'b1, ($urandom_range(3) == 0) ? $urandom : clock_ms,
						8'($urandom), fingers, 12'($urandom), 12'($urandom));
				end else begin
					clock_ms += pick_gap();
					if ($urandom_range(9) < 7)
						clock_ms += {16'd0, cur.cooldown_ms};
					x = $urandom_range(lim - 1, 0);
					y = $urandom_range(lim - 1, 0);
					case ($urandom_range(2))
						0: v = 2;
						1: v = int'(cur.swipe_min) / 2 + 4;
						default: v = lim / 6 + 1;
					endcase
					vx = int'($urandom_range(2 * v, 0)) - v;
					vy = int'($urandom_range(2 * v, 0)) - v;
					repeat ($urandom_range(6, 1)) begin
						send_poll(1'b1, clock_ms, ($urandom_range(9) == 0) ?
							8'($urandom_range(255, 1)) : tgr_pkg::CODE_NONE, 8'd1,
							12'(x), 12'(y));
						clock_ms += pick_gap();
						x = clamp_coord(x + vx);
						y = clamp_coord(y + vy);
					end
					rx = x;
					case ($urandom_range(5))
						0: fingers = 8'($urandom_range(255, 2));
						1: begin
							fingers = (lim < 4096) ? 8'd1 : 8'd0;
							if (lim < 4096)
								rx = $urandom_range(4095, lim);
						end
						default: fingers = 8'd0;
					endcase
					send_poll(1'b1, clock_ms,
						$urandom_range(1) ? 8'($urandom) : tgr_pkg::CODE_NONE,
						fingers, 12'(rx), 12'(y));
				end
			end
		end

		in_valid <= 1'b0;
		wait (pending == 0);
		repeat (10) @(posedge clk);
		$display("%0d polls sent under %0d settings, %0d results checked, %0d gestures emitted",
			polls_sent, PHASES + 1, results_checked, gestures_seen);
		if (mismatches == 0 && pending == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

`default_nettype wire
